// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked concurrent checks, held off while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clock.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/cfbl_pkg.sv =====
// ---------------------------------------------------------------------------
// cfbl_pkg
// Types and codes of the chained free block list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfbl_pkg;

   localparam int STACK_DEPTH_DEF = 50;
   localparam int WIDX_W          = 6;
   localparam int WORD_W          = 32;

   typedef logic [1:0] action_type;
   localparam action_type ACT_FREE   = 2'd0;
   localparam action_type ACT_ALLOC  = 2'd1;
   localparam action_type ACT_REFILL = 2'd2;

   typedef logic [2:0] kind_type;
   localparam kind_type K_ALLOC   = 3'd0;
   localparam kind_type K_SPILL   = 3'd1;
   localparam kind_type K_NOSPACE = 3'd2;
   localparam kind_type K_SEQERR  = 3'd3;
   localparam kind_type K_FREED   = 3'd4;
   localparam kind_type K_REFILL  = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_SPILL,
      ST_PUSH
   } state_type;

endpackage

// ===== src/chained_free_block_list.sv =====
// ---------------------------------------------------------------------------
// chained_free_block_list
// Free-block allocator: on-chip stack of free block numbers, overflow
// chained through the freed blocks.
// ---------------------------------------------------------------------------
// Use: req_action frees a block (req_block_number), allocates one, or
// delivers one refill word (req_refill_value). Each transfer on req gives
// one or more transfers on rsp; rsp_last marks the final one.
// The stack lives in a single-port-read, single-port-write RAM with a
// registered read port. One request is worked at a time.
// Free, refill word and sequence error results are registered straight
// from the request; alloc first reads the stack RAM (ST_ALLOC). A free onto
// a full stack streams the count and STACK_DEPTH entries, one per cycle
// while rsp is not stalled (ST_SPILL), then the free result (ST_PUSH).
// rsp is driven from an output register, so the next request is taken in
// the same cycle the previous result is transferred.
// Reset clears the stack count, free total and refill state and holds
// req_stall high; RAM contents are left as they are. When rsp_stall is
// high the result holds and the block holds req_stall high until the
// result moves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chained_free_block_list #(
   parameter int STACK_DEPTH = cfbl_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cfbl_pkg::action_type                req_action,
   input  logic [cfbl_pkg::WORD_W-1:0]         req_block_number,
   input  logic [cfbl_pkg::WORD_W-1:0]         req_refill_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cfbl_pkg::kind_type                  rsp_kind,
   output logic [cfbl_pkg::WORD_W-1:0]         rsp_value,
   output logic [cfbl_pkg::WIDX_W-1:0]         rsp_word_index,
   output logic [cfbl_pkg::WORD_W-1:0]         rsp_target_block,
   output logic                                rsp_needs_refill,
   output logic                                rsp_last,
   output logic signed [cfbl_pkg::WORD_W-1:0]  rsp_free_total
);

   import cfbl_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [WORD_W-1:0] mem [STACK_DEPTH];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [WORD_W-1:0] counter_ff, counter_in;
   logic              active_ff, active_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     sp_ff, sp_in;
   logic [WORD_W-1:0] bno_ff, bno_in;
   logic [WORD_W-1:0] rd_data_ff;

   logic              rsp_valid_ff;
   kind_type          kind_ff, kind_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic [WORD_W-1:0] target_ff, target_in;
   logic              refill_ff, refill_in;
   logic              last_ff, last_in;
   logic [WORD_W-1:0] total_ff;

   logic              out_free;
   logic              accept;
   logic              load;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [WORD_W-1:0] wdata;
   logic              re;
   logic [AW-1:0]     raddr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !active_ff) begin
               if (req_action == ACT_ALLOC && count_ff != '0) begin
                  state_in = ST_ALLOC;
               end else if (req_action == ACT_FREE && count_ff >= CW'(STACK_DEPTH)) begin
                  state_in = ST_SPILL;
               end
            end
         end
         ST_ALLOC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SPILL: begin
            if (out_free && sp_ff == AW'(STACK_DEPTH - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and result selection
   always_comb begin
      count_in   = count_ff;
      counter_in = counter_ff;
      active_in  = active_ff;
      pos_in     = pos_ff;
      sp_in      = sp_ff;
      bno_in     = bno_ff;
      load       = 1'b0;
      kind_in    = K_SEQERR;
      value_in   = '0;
      widx_in    = '0;
      target_in  = '0;
      refill_in  = 1'b0;
      last_in    = 1'b1;
      we         = 1'b0;
      waddr      = '0;
      wdata      = req_block_number;
      re         = 1'b0;
      raddr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load   = 1'b1;
               bno_in = req_block_number;
               if (req_action == ACT_FREE && !active_ff) begin
                  if (req_block_number != '0) begin
                     counter_in = counter_ff + 1'b1;
                  end
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     kind_in   = K_SPILL;
                     value_in  = WORD_W'(count_ff);
                     target_in = req_block_number;
                     last_in   = 1'b0;
                     re        = 1'b1;
                     raddr     = '0;
                     sp_in     = '0;
                  end else begin
                     we       = 1'b1;
                     waddr    = AW'(count_ff);
                     count_in = count_ff + 1'b1;
                     kind_in  = K_FREED;
                     value_in = req_block_number;
                  end
               end else if (req_action == ACT_ALLOC && !active_ff && count_ff != '0) begin
                  load       = 1'b0;
                  counter_in = counter_ff - 1'b1;
                  count_in   = count_ff - 1'b1;
                  re         = 1'b1;
                  raddr      = AW'(count_ff - 1'b1);
               end else if (req_action == ACT_REFILL && active_ff) begin
                  if (pos_ff == '0) begin
                     count_in = (req_refill_value > WORD_W'(STACK_DEPTH)) ?
                                CW'(STACK_DEPTH) : req_refill_value[CW-1:0];
                  end else begin
                     we    = 1'b1;
                     waddr = AW'(pos_ff - 1'b1);
                     wdata = req_refill_value;
                  end
                  if (pos_ff >= CW'(STACK_DEPTH)) begin
                     active_in = 1'b0;
                     pos_in    = '0;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
                  kind_in  = K_REFILL;
                  value_in = req_refill_value;
                  widx_in  = WIDX_W'(pos_ff);
               end
            end
         end
         ST_ALLOC: begin
            if (out_free) begin
               load = 1'b1;
               if (rd_data_ff == '0) begin
                  kind_in = K_NOSPACE;
               end else begin
                  kind_in  = K_ALLOC;
                  value_in = rd_data_ff;
                  if (count_ff == '0) begin
                     target_in = rd_data_ff;
                     refill_in = 1'b1;
                     active_in = 1'b1;
                     pos_in    = '0;
                  end
               end
            end
         end
         ST_SPILL: begin
            if (out_free) begin
               load      = 1'b1;
               kind_in   = K_SPILL;
               value_in  = rd_data_ff;
               widx_in   = WIDX_W'(sp_ff) + 1'b1;
               target_in = bno_ff;
               last_in   = 1'b0;
               if (sp_ff != AW'(STACK_DEPTH - 1)) begin
                  re    = 1'b1;
                  raddr = sp_ff + 1'b1;
                  sp_in = sp_ff + 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               load     = 1'b1;
               we       = 1'b1;
               waddr    = '0;
               wdata    = bno_ff;
               count_in = CW'(1);
               kind_in  = K_FREED;
               value_in = bno_ff;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         counter_ff   <= '0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         counter_ff <= counter_in;
         active_ff  <= active_in;
         pos_ff     <= pos_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sp_ff  <= sp_in;
      bno_ff <= bno_in;
      if (load) begin
         kind_ff   <= kind_in;
         value_ff  <= value_in;
         widx_ff   <= widx_in;
         target_ff <= target_in;
         refill_ff <= refill_in;
         last_ff   <= last_in;
         total_ff  <= counter_in;
      end
   end

   // stack RAM
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_value        = value_ff;
   assign rsp_word_index   = widx_ff;
   assign rsp_target_block = target_ff;
   assign rsp_needs_refill = refill_ff;
   assign rsp_last         = last_ff;
   assign rsp_free_total   = $signed(total_ff);

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(STACK_DEPTH), "stack count above depth")
   `ASSERT_IMPLY(a_busy_stall, state_ff != ST_IDLE, req_stall, "request taken while busy")
   `ASSERT_IMPLY(a_spill_full, state_ff == ST_SPILL, count_ff == CW'(STACK_DEPTH), "spill on non-full stack")
   `ASSERT_IMPLY(a_pos_active, pos_ff != '0, active_ff, "refill position without refill")

endmodule
